@@ sv/bsc_pkg.sv @@
// Shared types and constants for the barometric sensor compensation block.
// Holds register indexes, algorithm constants and the sideband records that
// travel beside the two pipelined dividers. No dependencies.
package bsc_pkg;

	localparam int DIV_W   = 32;
	localparam int DIV_LAT = DIV_W;

	typedef enum logic [2:0] {
		CFG_AC1_AC2 = 3'd0,
		CFG_AC3_AC4 = 3'd1,
		CFG_AC5_AC6 = 3'd2,
		CFG_B1_B2   = 3'd3,
		CFG_MC_MD   = 3'd4,
		CFG_OSS     = 3'd5
	} cfg_idx_t;

	localparam logic signed [31:0] B6_OFFSET  = 32'sd4000;
	localparam logic signed [31:0] P_C1       = 32'sd3038;
	localparam logic signed [31:0] P_C2       = -32'sd7357;
	localparam logic signed [31:0] P_C3       = 32'sd3791;
	localparam logic        [31:0] P_SCALE    = 32'd50000;
	localparam logic        [31:0] B4_OFFSET  = 32'd32768;
	localparam logic        [31:0] B7_HALF    = 32'h8000_0000;

	// Rides beside the temperature divider.
	typedef struct packed {
		logic signed [31:0] x1;
		logic               neg;
		logic               zero;
		logic        [18:0] up;
	} tside_t;

	// Rides beside the pressure divider.
	typedef struct packed {
		logic               err;
		logic        [15:0] temp;
		logic               hi;
	} pside_t;

endpackage

@@ sv/baro_sensor_compensation.sv @@
// Barometric sensor compensation (temperature and pressure), top level.
// Uses bsc_pkg and two bsc_div32 pipelined dividers.
//
// Usage: raw sample pairs enter on the s_ stream (one pair per beat) and
// one compensated result leaves on the m_ stream per input beat, in order.
// Calibration words and the oversampling setting are written through the
// cfg_ channel while no sample is in flight; cfg_ready is always high.
// The pipeline is eleven arithmetic stages plus two 32-stage dividers
// (temperature divide, then pressure divide).
// Throughput is one pair per cycle while the receiver does not stall; the
// whole pipeline moves as one and the last stage is the output register.
// When the receiver stalls with a result waiting, every stage holds and
// s_tready drops in the same cycle, so no beat is lost or repeated.
// Reset clears all valid bits and the configuration registers to zero.
// A zero divisor on either path gives m_tuser = 1 with all data zero.
module baro_sensor_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // raw_temperature[15:0], raw_pressure[34:16], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // temperature_tenths[15:0], pressure_pa[47:16]
	output logic        m_tuser    // divide_error
);

	logic [31:0] ac12_q, ac34_q, ac56_q, b12_q, mcmd_q;
	logic [1:0]  oss_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ac12_q <= '0;
			ac34_q <= '0;
			ac56_q <= '0;
			b12_q  <= '0;
			mcmd_q <= '0;
			oss_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				bsc_pkg::CFG_AC1_AC2: ac12_q <= cfg_data;
				bsc_pkg::CFG_AC3_AC4: ac34_q <= cfg_data;
				bsc_pkg::CFG_AC5_AC6: ac56_q <= cfg_data;
				bsc_pkg::CFG_B1_B2:   b12_q  <= cfg_data;
				bsc_pkg::CFG_MC_MD:   mcmd_q <= cfg_data;
				bsc_pkg::CFG_OSS:     oss_q  <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	logic signed [31:0] ac1, ac2, ac3, b1, b2, mc, md;
	logic        [31:0] ac4, ac5, ac6;

	assign ac1 = {{16{ac12_q[31]}}, ac12_q[31:16]};
	assign ac2 = {{16{ac12_q[15]}}, ac12_q[15:0]};
	assign ac3 = {{16{ac34_q[31]}}, ac34_q[31:16]};
	assign ac4 = {16'd0, ac34_q[15:0]};
	assign ac5 = {16'd0, ac56_q[31:16]};
	assign ac6 = {16'd0, ac56_q[15:0]};
	assign b1  = {{16{b12_q[31]}}, b12_q[31:16]};
	assign b2  = {{16{b12_q[15]}}, b12_q[15:0]};
	assign mc  = {{16{mcmd_q[31]}}, mcmd_q[31:16]};
	assign md  = {{16{mcmd_q[15]}}, mcmd_q[15:0]};

	logic en;
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// Stage 1: X1 of the temperature path.
	logic               v_s1;
	logic signed [31:0] x1_s1;
	logic        [18:0] up_s1;
	logic signed [16:0] dut;
	logic signed [33:0] p1;

	assign dut = $signed({1'b0, s_tdata[15:0]}) - $signed({1'b0, ac6[15:0]});
	assign p1  = dut * $signed({1'b0, ac5[15:0]});

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s1 <= $signed(p1[31:0]) >>> 15;
			up_s1 <= s_tdata[34:16];
		end
	end

	// Stage 2: divisor, sign split for the unsigned divider.
	logic               v_s2;
	logic signed [31:0] den_s2;
	logic        [31:0] num_s2;
	bsc_pkg::tside_t    ts_s2;
	logic signed [31:0] den_c;
	logic signed [31:0] mc_abs;

	assign den_c  = x1_s1 + md;
	assign mc_abs = mc[31] ? -mc : mc;

	always_ff @(posedge clk) begin
		if (en) begin
			den_s2     <= den_c;
			num_s2     <= 32'(mc_abs) << 11;
			ts_s2.x1   <= x1_s1;
			ts_s2.neg  <= mc[31] ^ den_c[31];
			ts_s2.zero <= (den_c == 32'sd0);
			ts_s2.up   <= up_s1;
		end
	end

	logic [31:0] tquot;
	logic [31:0] tden;
	assign tden = den_s2[31] ? 32'(-den_s2) : 32'(den_s2);

	bsc_div32 u_tdiv (
		.clk  (clk),
		.en   (en),
		.num  (num_s2),
		.den  (tden),
		.quot (tquot)
	);

	bsc_pkg::tside_t tsd_q [bsc_pkg::DIV_LAT];
	logic            tvd_q [bsc_pkg::DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			tsd_q[0] <= ts_s2;
			for (int i = 1; i < bsc_pkg::DIV_LAT; i++) tsd_q[i] <= tsd_q[i-1];
		end
	end

	// Stage 3: B5, temperature, B6.
	logic               v_s3;
	logic signed [31:0] b6_s3;
	logic        [15:0] t_s3;
	logic               dz_s3;
	logic        [18:0] up_s3;
	logic signed [31:0] x2t, b5, t32;
	bsc_pkg::tside_t    tt;

	assign tt  = tsd_q[bsc_pkg::DIV_LAT-1];
	assign x2t = tt.neg ? -$signed(tquot) : $signed(tquot);
	assign b5  = tt.x1 + x2t;
	assign t32 = (b5 + 32'sd8) >>> 4;

	always_ff @(posedge clk) begin
		if (en) begin
			b6_s3 <= b5 - bsc_pkg::B6_OFFSET;
			t_s3  <= t32[15:0];
			dz_s3 <= tt.zero;
			up_s3 <= tt.up;
		end
	end

	// Stage 4: products of B6.
	logic               v_s4;
	logic signed [31:0] b66_s4, x2a_s4, x1c_s4;
	logic        [15:0] t_s4;
	logic               dz_s4;
	logic        [18:0] up_s4;
	logic signed [31:0] sq, m_ac2, m_ac3;

	assign sq    = b6_s3 * b6_s3;
	assign m_ac2 = ac2 * b6_s3;
	assign m_ac3 = ac3 * b6_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			b66_s4 <= sq >>> 12;
			x2a_s4 <= m_ac2 >>> 11;
			x1c_s4 <= m_ac3 >>> 13;
			t_s4   <= t_s3;
			dz_s4  <= dz_s3;
			up_s4  <= up_s3;
		end
	end

	// Stage 5: products of the squared term.
	logic               v_s5;
	logic signed [31:0] x1a_s5, x2a_s5, x1c_s5, x2c_s5;
	logic        [15:0] t_s5;
	logic               dz_s5;
	logic        [18:0] up_s5;
	logic signed [31:0] m_b2, m_b1;

	assign m_b2 = b2 * b66_s4;
	assign m_b1 = b1 * b66_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			x1a_s5 <= m_b2 >>> 11;
			x2c_s5 <= m_b1 >>> 16;
			x2a_s5 <= x2a_s4;
			x1c_s5 <= x1c_s4;
			t_s5   <= t_s4;
			dz_s5  <= dz_s4;
			up_s5  <= up_s4;
		end
	end

	// Stage 6: B3 before rounding, X3 for B4.
	logic               v_s6;
	logic signed [31:0] b3p_s6, x3c_s6;
	logic        [15:0] t_s6;
	logic               dz_s6;
	logic        [18:0] up_s6;
	logic signed [31:0] sum3;

	assign sum3 = (ac1 <<< 2) + x1a_s5 + x2a_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			b3p_s6 <= sum3 << oss_q;
			x3c_s6 <= (x1c_s5 + x2c_s5 + 32'sd2) >>> 2;
			t_s6   <= t_s5;
			dz_s6  <= dz_s5;
			up_s6  <= up_s5;
		end
	end

	// Stage 7: B3 and B4.
	logic               v_s7;
	logic signed [31:0] b3_s7;
	logic        [16:0] b4_s7;
	logic        [15:0] t_s7;
	logic               dz_s7;
	logic        [18:0] up_s7;
	logic        [31:0] b4p;

	assign b4p = ac4 * (32'(x3c_s6) + bsc_pkg::B4_OFFSET);

	always_ff @(posedge clk) begin
		if (en) begin
			b3_s7 <= (b3p_s6 + 32'sd2) >>> 2;
			b4_s7 <= b4p[31:15];
			t_s7  <= t_s6;
			dz_s7 <= dz_s6;
			up_s7 <= up_s6;
		end
	end

	// Stage 8: B7.
	logic               v_s8;
	logic        [31:0] b7_s8;
	logic        [16:0] b4_s8;
	bsc_pkg::pside_t    ps_s8;
	logic        [31:0] updiff;

	assign updiff = {13'd0, up_s7} - 32'(b3_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			b7_s8      <= updiff * (bsc_pkg::P_SCALE >> oss_q);
			b4_s8      <= b4_s7;
			ps_s8.err  <= dz_s7 || (b4_s7 == 17'd0);
			ps_s8.temp <= t_s7;
			ps_s8.hi   <= 1'b0;
		end
	end

	// A large B7 is divided first and doubled after, a small one doubled first.
	logic [31:0] pquot;
	logic [31:0] pnum;
	bsc_pkg::pside_t ps_in;

	assign pnum = (b7_s8 >= bsc_pkg::B7_HALF) ? b7_s8 : (b7_s8 << 1);
	always_comb begin
		ps_in    = ps_s8;
		ps_in.hi = (b7_s8 >= bsc_pkg::B7_HALF);
	end

	bsc_div32 u_pdiv (
		.clk  (clk),
		.en   (en),
		.num  (pnum),
		.den  ({15'd0, b4_s8}),
		.quot (pquot)
	);

	bsc_pkg::pside_t psd_q [bsc_pkg::DIV_LAT];
	logic            pvd_q [bsc_pkg::DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			psd_q[0] <= ps_in;
			for (int i = 1; i < bsc_pkg::DIV_LAT; i++) psd_q[i] <= psd_q[i-1];
		end
	end

	// Stage 9: P and the first correction products.
	logic               v_s9;
	logic signed [31:0] p_s9, x1sq_s9, m2_s9;
	logic               err_s9;
	logic        [15:0] t_s9;
	logic signed [31:0] p_c, x1p;
	bsc_pkg::pside_t    pp;

	assign pp  = psd_q[bsc_pkg::DIV_LAT-1];
	assign p_c = pp.hi ? $signed(pquot << 1) : $signed(pquot);
	assign x1p = p_c >>> 8;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s9    <= p_c;
			x1sq_s9 <= x1p * x1p;
			m2_s9   <= bsc_pkg::P_C2 * p_c;
			err_s9  <= pp.err;
			t_s9    <= pp.temp;
		end
	end

	// Stage 10: correction sum.
	logic               v_s10;
	logic signed [31:0] p_s10, sum_s10;
	logic               err_s10;
	logic        [15:0] t_s10;
	logic signed [31:0] m1p;

	assign m1p = x1sq_s9 * bsc_pkg::P_C1;

	always_ff @(posedge clk) begin
		if (en) begin
			p_s10   <= p_s9;
			sum_s10 <= (m1p >>> 16) + (m2_s9 >>> 16) + bsc_pkg::P_C3;
			err_s10 <= err_s9;
			t_s10   <= t_s9;
		end
	end

	// Stage 11: output register.
	logic signed [31:0] p_fin;
	assign p_fin = p_s10 + (sum_s10 >>> 4);

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= err_s10 ? 48'd0 : {p_fin, t_s10};
			m_tuser <= err_s10;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			v_s4     <= 1'b0;
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			v_s9     <= 1'b0;
			v_s10    <= 1'b0;
			m_tvalid <= 1'b0;
			for (int i = 0; i < bsc_pkg::DIV_LAT; i++) begin
				tvd_q[i] <= 1'b0;
				pvd_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s1     <= s_tvalid;
			v_s2     <= v_s1;
			tvd_q[0] <= v_s2;
			for (int i = 1; i < bsc_pkg::DIV_LAT; i++) tvd_q[i] <= tvd_q[i-1];
			v_s3     <= tvd_q[bsc_pkg::DIV_LAT-1];
			v_s4     <= v_s3;
			v_s5     <= v_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			pvd_q[0] <= v_s8;
			for (int i = 1; i < bsc_pkg::DIV_LAT; i++) pvd_q[i] <= pvd_q[i-1];
			v_s9     <= pvd_q[bsc_pkg::DIV_LAT-1];
			v_s10    <= v_s9;
			m_tvalid <= v_s10;
		end
	end

endmodule

@@ sv/bsc_div32.sv @@
// Unsigned 32 by 32 bit restoring divider, one quotient bit per stage.
// Uses bsc_pkg.
module bsc_div32 (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] num,
	input  logic [31:0] den,
	output logic [31:0] quot
);

	logic [31:0] rem_s [bsc_pkg::DIV_LAT+1];
	logic [31:0] nq_s  [bsc_pkg::DIV_LAT+1];
	logic [31:0] den_s [bsc_pkg::DIV_LAT+1];

	assign rem_s[0] = '0;
	assign nq_s[0]  = num;
	assign den_s[0] = den;

	for (genvar k = 0; k < bsc_pkg::DIV_LAT; k++) begin : g_step
		logic [32:0] sh;
		logic [32:0] diff;
		logic        ge;

		always_comb begin
			sh   = {rem_s[k], nq_s[k][31]};
			diff = sh - {1'b0, den_s[k]};
			ge   = (sh >= {1'b0, den_s[k]});
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= ge ? diff[31:0] : sh[31:0];
				nq_s[k+1]  <= {nq_s[k][30:0], ge};
				den_s[k+1] <= den_s[k];
			end
		end
	end

	assign quot = nq_s[bsc_pkg::DIV_LAT];

endmodule

@@ sv/bsc_chk.sv @@
// Port-level checks for the barometric sensor compensation block.
// Bound to baro_sensor_compensation; no package dependency.
module bsc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [2:0]  cfg_index,
	input logic [31:0] cfg_data,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [39:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser
);

	// A result beat that is not taken stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A zero divisor forces all result data to zero.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 48'd0)
		else $error("divide error with nonzero data");

	// The input side is open exactly when the output register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("result offered straight out of reset");

endmodule

bind baro_sensor_compensation bsc_chk u_bsc_chk (.*);
